/* sv/mrpt_pkg.sv */
`timescale 1ns / 1ps
package mrpt_pkg;

	// Largest supported candidate width.
	localparam int unsigned WidthDefault = 64;
	// Width of the candidate and random word ports.
	localparam int unsigned WordBits = 64;
	localparam int unsigned Rounds = 4;
	localparam int unsigned RoundBits = $clog2(Rounds);

	// Commands handed from the sequencer to the shared modular unit.
	typedef enum logic [1:0] {
		OP_MULMOD = 2'd0,
		OP_REDUCE = 2'd1
	} mrpt_op_t;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SPLIT,
		ST_BASE_GO,
		ST_BASE_WAIT,
		ST_EXP_STEP,
		ST_EXP_MUL_WAIT,
		ST_EXP_SQR_WAIT,
		ST_CHECK,
		ST_SQR_WAIT,
		ST_DONE
	} mrpt_state_t;

	// Request and reply between the sequencer and the modular unit.
	typedef struct packed {
		logic     go;
		mrpt_op_t op;
	} mrpt_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} mrpt_rsp_t;

endpackage

/* sv/miller_rabin_prime_test_core.sv */
`timescale 1ns / 1ps
// Channel  | Ports                                   | Transfer
// ---------+-----------------------------------------+----------------------------
// input    | candidate, random_word_0..3             | start high while busy low
// result   | probably_prime                          | strobe high, one cycle
//
// One candidate takes a setup that splits n-1, up to four rounds and a finish. A round reduces
// its random word and then runs modular multiplies: one per bit of d, one more per set bit of d
// and up to s - 1 squarings.
// Small and even candidates are settled without any rounds.
// Reset clears the sequencer; the block then waits idle for start.
// The receiver cannot stall: the result shows for one cycle, starting as busy falls.
module miller_rabin_prime_test_core #(
	parameter int unsigned WIDTH = mrpt_pkg::WidthDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [63:0] candidate,
	input  logic [63:0] random_word_0,
	input  logic [63:0] random_word_1,
	input  logic [63:0] random_word_2,
	input  logic [63:0] random_word_3,
	output logic        strobe,
	output logic        probably_prime
);
	import mrpt_pkg::*;

	mrpt_req_t           req;
	mrpt_rsp_t           rsp;
	logic [WIDTH-1:0]    op_x;
	logic [WordBits-1:0] op_y;
	logic [WIDTH-1:0]    op_n;
	logic [WIDTH-1:0]    res;

	// Sequencer.
	mrpt_seq #(.WIDTH(WIDTH)) u_seq (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.candidate      (candidate),
		.random_word_0  (random_word_0),
		.random_word_1  (random_word_1),
		.random_word_2  (random_word_2),
		.random_word_3  (random_word_3),
		.busy           (busy),
		.strobe         (strobe),
		.probably_prime (probably_prime),
		.req            (req),
		.op_x           (op_x),
		.op_y           (op_y),
		.op_n           (op_n),
		.rsp            (rsp),
		.res            (res)
	);

	// Shared modular multiply and reduce unit.
	mrpt_modunit #(.WIDTH(WIDTH)) u_modunit (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.x      (op_x),
		.y      (op_y),
		.n      (op_n),
		.rsp    (rsp),
		.res    (res)
	);

`ifndef NO_ASSERTIONS
	// The unit is only started while it is free.
	a_go_free: assert property (@(posedge clk) disable iff (!arst_n)
		req.go |-> !rsp.busy)
		else $error("modular unit started while busy");

	// A result strobe always follows the end of a busy period.
	a_strobe_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> !busy && $past(busy))
		else $error("strobe without a finished item");

	// The unit finishes only what was started.
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |-> $past(rsp.busy))
		else $error("modular unit done while idle");
`endif

endmodule

/* sv/mrpt_modunit.sv */
`timescale 1ns / 1ps
// Shared modular unit. OP_MULMOD computes x*y mod n by one shift-add-reduce step per
// cycle over the WIDTH bits of y. OP_REDUCE computes y mod n by restoring division,
// one dividend bit per cycle over all 64 bits of the word on y.
module mrpt_modunit #(
	parameter int unsigned WIDTH = mrpt_pkg::WidthDefault
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mrpt_pkg::mrpt_req_t           req,
	input  logic [WIDTH-1:0]              x,
	input  logic [mrpt_pkg::WordBits-1:0] y,
	input  logic [WIDTH-1:0]              n,
	output mrpt_pkg::mrpt_rsp_t           rsp,
	output logic [WIDTH-1:0]              res
);
	import mrpt_pkg::*;

	localparam int unsigned CntBits = $clog2(WordBits);

	logic                busy_q;
	logic                done_q;
	mrpt_op_t            op_q;
	logic [CntBits-1:0]  cnt_q;
	logic [WIDTH-1:0]    acc_q;
	logic [WIDTH-1:0]    x_q;
	logic [WordBits-1:0] y_q;
	logic [WIDTH-1:0]    n_q;

	logic [WIDTH:0]   dbl;
	logic [WIDTH-1:0] dbl_red;
	logic [WIDTH:0]   sum;
	logic [WIDTH-1:0] sum_red;
	logic [WIDTH-1:0] acc_next;

	// One step: double acc, shift in the next bit, reduce; a multiply adds x on a set bit.
	always_comb begin
		dbl = {acc_q, (op_q == OP_REDUCE) ? y_q[WordBits-1] : 1'b0};
		if (dbl >= {1'b0, n_q}) begin
			dbl_red = WIDTH'(dbl - {1'b0, n_q});
		end else begin
			dbl_red = dbl[WIDTH-1:0];
		end
		sum = {1'b0, dbl_red} + {1'b0, x_q};
		if (sum >= {1'b0, n_q}) begin
			sum_red = WIDTH'(sum - {1'b0, n_q});
		end else begin
			sum_red = sum[WIDTH-1:0];
		end
		if (op_q == OP_MULMOD && y_q[WordBits-1]) begin
			acc_next = sum_red;
		end else begin
			acc_next = dbl_red;
		end
	end

	// Control: WIDTH steps for a multiply, one per word bit for a reduction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.go && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= (req.op == OP_REDUCE) ? CntBits'(WordBits - 1) : CntBits'(WIDTH - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// Operands and accumulator. A multiplier is aligned to the top of the shift register.
	always_ff @(posedge clk) begin
		if (req.go && !busy_q) begin
			op_q  <= req.op;
			acc_q <= '0;
			x_q   <= x;
			y_q   <= (req.op == OP_REDUCE) ? y : (y << (WordBits - WIDTH));
			n_q   <= n;
		end else if (busy_q) begin
			acc_q <= acc_next;
			y_q   <= {y_q[WordBits-2:0], 1'b0};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign res      = acc_q;

endmodule

/* sv/mrpt_seq.sv */
`timescale 1ns / 1ps
// Sequencer: splits n-1 into d*2^s, picks each round's base and walks the
// exponentiation and the squaring chain through the shared modular unit.
module mrpt_seq #(
	parameter int unsigned WIDTH = mrpt_pkg::WidthDefault
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [63:0]                   candidate,
	input  logic [63:0]                   random_word_0,
	input  logic [63:0]                   random_word_1,
	input  logic [63:0]                   random_word_2,
	input  logic [63:0]                   random_word_3,
	output logic                          busy,
	output logic                          strobe,
	output logic                          probably_prime,
	output mrpt_pkg::mrpt_req_t           req,
	output logic [WIDTH-1:0]              op_x,
	output logic [mrpt_pkg::WordBits-1:0] op_y,
	output logic [WIDTH-1:0]              op_n,
	input  mrpt_pkg::mrpt_rsp_t           rsp,
	input  logic [WIDTH-1:0]              res
);
	import mrpt_pkg::*;

	localparam int unsigned SBits = $clog2(WIDTH + 1);

	mrpt_state_t state_q, state_d;

	logic [WIDTH-1:0]     n_q;
	logic [WIDTH-1:0]     d_q;
	logic [SBits-1:0]     s_q;
	logic [SBits-1:0]     i_q;
	logic [RoundBits-1:0] round_q;
	logic [Rounds-1:0][63:0] rnd_q;
	logic [WIDTH-1:0]     base_q;
	logic [WIDTH-1:0]     acc_q;
	logic [WIDTH-1:0]     e_q;
	logic                 result_q;
	logic                 strobe_q;

	logic [WIDTH-1:0] n_in;
	logic             accept;
	logic             trivial;
	logic             trivial_val;
	logic [WIDTH-1:0] nm1;
	logic             last_round;
	logic             x_pass;

	assign n_in       = candidate[WIDTH-1:0];
	assign accept     = start && (state_q == ST_IDLE);
	assign nm1        = n_q - 1'b1;
	assign last_round = (round_q == RoundBits'(Rounds - 1));
	assign x_pass     = (acc_q == WIDTH'(1)) || (acc_q == nm1);

	// Small and even candidates are settled without any rounds.
	always_comb begin
		trivial     = 1'b1;
		trivial_val = 1'b0;
		if (n_in < WIDTH'(2)) begin
			trivial_val = 1'b0;
		end else if (n_in < WIDTH'(4)) begin
			trivial_val = 1'b1;
		end else if (!n_in[0]) begin
			trivial_val = 1'b0;
		end else begin
			trivial = 1'b0;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = trivial ? ST_DONE : ST_SPLIT;
				end
			end
			ST_SPLIT: begin
				if (d_q[0]) begin
					state_d = ST_BASE_GO;
				end
			end
			ST_BASE_GO: state_d = ST_BASE_WAIT;
			ST_BASE_WAIT: begin
				if (rsp.done) begin
					state_d = ST_EXP_STEP;
				end
			end
			ST_EXP_STEP: begin
				if (e_q == '0) begin
					state_d = ST_CHECK;
				end else if (e_q[0]) begin
					state_d = ST_EXP_MUL_WAIT;
				end else begin
					state_d = ST_EXP_SQR_WAIT;
				end
			end
			ST_EXP_MUL_WAIT: begin
				if (rsp.done) begin
					state_d = ST_EXP_SQR_WAIT;
				end
			end
			ST_EXP_SQR_WAIT: begin
				if (rsp.done) begin
					state_d = ST_EXP_STEP;
				end
			end
			ST_CHECK: begin
				if (i_q == '0 ? x_pass : (acc_q == nm1)) begin
					state_d = last_round ? ST_DONE : ST_BASE_GO;
				end else if (i_q != '0 && acc_q == WIDTH'(1)) begin
					state_d = ST_DONE;
				end else if (SBits'(i_q + 1'b1) >= s_q) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_SQR_WAIT;
				end
			end
			ST_SQR_WAIT: begin
				if (rsp.done) begin
					state_d = ST_CHECK;
				end
			end
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Requests to the modular unit.
	always_comb begin
		req.go = 1'b0;
		req.op = OP_MULMOD;
		op_x   = acc_q;
		op_y   = WordBits'(base_q);
		op_n   = n_q;
		unique case (state_q)
			ST_BASE_GO: begin
				req.go = 1'b1;
				req.op = OP_REDUCE;
				op_x   = '0;
				op_y   = rnd_q[round_q];
				op_n   = n_q - WIDTH'(3);
			end
			ST_EXP_STEP: begin
				if (e_q != '0) begin
					req.go = 1'b1;
					if (e_q[0]) begin
						op_x = acc_q;
						op_y = WordBits'(base_q);
					end else begin
						op_x = base_q;
						op_y = WordBits'(base_q);
					end
				end
			end
			ST_EXP_MUL_WAIT: begin
				if (rsp.done) begin
					req.go = 1'b1;
					op_x   = base_q;
					op_y   = WordBits'(base_q);
				end
			end
			ST_CHECK: begin
				if (state_d == ST_SQR_WAIT) begin
					req.go = 1'b1;
					op_x   = acc_q;
					op_y   = WordBits'(acc_q);
				end
			end
			default: begin
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			strobe_q <= 1'b0;
			result_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			strobe_q <= (state_q == ST_DONE);
			if (accept) begin
				result_q <= trivial_val;
			end else if (state_q == ST_CHECK && state_d == ST_DONE) begin
				result_q <= last_round && (i_q == '0 ? x_pass : (acc_q == nm1));
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				n_q      <= n_in;
				d_q      <= n_in - 1'b1;
				s_q      <= '0;
				round_q  <= '0;
				rnd_q[0] <= random_word_0;
				rnd_q[1] <= random_word_1;
				rnd_q[2] <= random_word_2;
				rnd_q[3] <= random_word_3;
			end
			ST_SPLIT: begin
				if (!d_q[0]) begin
					d_q <= {1'b0, d_q[WIDTH-1:1]};
					s_q <= s_q + 1'b1;
				end
			end
			ST_BASE_WAIT: begin
				if (rsp.done) begin
					// The reduced word lies below n - 3, so the base lands in [2, n - 2].
					base_q <= res + WIDTH'(2);
					acc_q  <= WIDTH'(1);
					e_q    <= d_q;
					i_q    <= '0;
				end
			end
			ST_EXP_MUL_WAIT: begin
				if (rsp.done) begin
					acc_q <= res;
				end
			end
			ST_EXP_SQR_WAIT: begin
				if (rsp.done) begin
					base_q <= res;
					e_q    <= {1'b0, e_q[WIDTH-1:1]};
				end
			end
			ST_CHECK: begin
				if (state_d == ST_BASE_GO) begin
					round_q <= round_q + 1'b1;
				end
			end
			ST_SQR_WAIT: begin
				if (rsp.done) begin
					acc_q <= res;
					i_q   <= i_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign busy           = (state_q != ST_IDLE);
	assign strobe         = strobe_q;
	assign probably_prime = result_q;

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
module tb;

	// Candidate record handed to the driver.
	typedef struct {
		logic [63:0] cand;
		logic [63:0] rw [4];
	} cand_item_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [63:0] candidate;
	logic [63:0] random_word_0;
	logic [63:0] random_word_1;
	logic [63:0] random_word_2;
	logic [63:0] random_word_3;
	logic        strobe;
	logic        probably_prime;

	cand_item_t  pending_cands [$];
	logic        verdicts_due [$];
	int          errors;
	int          verdicts_seen;
	int          primes_seen;
	int          send_idle_pct;
	bit          hold_sender;

	miller_rabin_prime_test_core #(.WIDTH(64)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.candidate(candidate),
		.random_word_0(random_word_0),
		.random_word_1(random_word_1),
		.random_word_2(random_word_2),
		.random_word_3(random_word_3),
		.strobe(strobe),
		.probably_prime(probably_prime)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// (x * y) mod n by shift-and-add, with x, y < n.
	function automatic logic [63:0] mulmod64(logic [63:0] x, logic [63:0] y, logic [63:0] n);
		logic [64:0] acc;
		acc = '0;
		for (int b = 63; b >= 0; b--) begin
			acc = acc << 1;
			if (acc >= {1'b0, n}) acc = acc - n;
			if (y[b]) begin
				acc = acc + x;
				if (acc >= {1'b0, n}) acc = acc - n;
			end
		end
		return acc[63:0];
	endfunction

	// Four-round witness test of one candidate.
	function automatic logic primality_verdict(cand_item_t it);
		logic [63:0] n, d, a, x, e, b;
		int unsigned s;
		bit passed;
		n = it.cand;
		if (n < 2) return 1'b0;
		if (n < 4) return 1'b1;
		if (!n[0]) return 1'b0;
		d = n - 1;
		s = 0;
		while (!d[0]) begin
			d = d >> 1;
			s++;
		end
		for (int r = 0; r < 4; r++) begin
			a = 64'd2 + (it.rw[r] % (n - 3));
			x = 1;
			e = d;
			b = a;
			while (e != 0) begin
				if (e[0]) x = mulmod64(x, b, n);
				e = e >> 1;
				b = mulmod64(b, b, n);
			end
			passed = (x == 1) || (x == n - 1);
			for (int unsigned i = 1; i < s && !passed; i++) begin
				x = mulmod64(x, x, n);
				if (x == n - 1) passed = 1;
				else if (x == 1) break;
			end
			if (!passed) return 1'b0;
		end
		return 1'b1;
	endfunction

	// Append one candidate to the tail of the pending list.
	function automatic void queue_item(cand_item_t it);
		pending_cands.insert(pending_cands.size(), it);
	endfunction

	// Drive a new candidate, unless held or randomly idle, once the previous transfer has gone.
	always @(negedge clk) begin
		if (!arst_n) begin
			start         <= 1'b0;
			candidate     <= '0;
			random_word_0 <= '0;
			random_word_1 <= '0;
			random_word_2 <= '0;
			random_word_3 <= '0;
		end else if (!(start && busy) && !hold_sender) begin
			if (pending_cands.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
				candidate     <= pending_cands[0].cand;
				random_word_0 <= pending_cands[0].rw[0];
				random_word_1 <= pending_cands[0].rw[1];
				random_word_2 <= pending_cands[0].rw[2];
				random_word_3 <= pending_cands[0].rw[3];
				start         <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Pop the driven candidate at its transfer and queue its verdict.
	always @(posedge clk) begin
		if (arst_n && start && !busy) begin
			verdicts_due.insert(verdicts_due.size(),
				primality_verdict(pending_cands.pop_front()));
		end
	end

	// Check each strobed verdict against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && strobe) begin
			if (verdicts_due.size() == 0) begin
				$display("%0t: unexpected result probably_prime=%0b", $realtime, probably_prime);
				errors++;
			end else begin
				logic want;
				want = verdicts_due.pop_front();
				verdicts_seen++;
				if (want) primes_seen++;
				if (probably_prime !== want) begin
					$display("%0t: probably_prime expected %0b actual %0b",
						$realtime, want, probably_prime);
					errors++;
				end
			end
		end
	end

	function automatic cand_item_t make_item(logic [63:0] c);
		cand_item_t it;
		it.cand = c;
		for (int r = 0; r < 4; r++) it.rw[r] = {$urandom, $urandom};
		return it;
	endfunction

	function automatic logic [63:0] rand_odd(int bits);
		logic [63:0] v;
		v = {$urandom, $urandom};
		if (bits < 64) v = v & ((64'd1 << bits) - 1);
		return v | 64'd1;
	endfunction

	// Wait until every candidate is sent and every verdict has come back.
	task automatic drain();
		while (pending_cands.size() != 0 || start || verdicts_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (10) @(posedge clk);
	endtask

	initial begin
		cand_item_t it;
		logic [63:0] known_primes [6];
		known_primes = '{64'd5, 64'd7, 64'd65537, 64'd2147483647,
			64'd18446744073709551557, 64'd1000000007};
		arst_n = 1'b0;
		errors = 0;
		verdicts_seen = 0;
		primes_seen = 0;
		send_idle_pct = 0;
		hold_sender = 0;
		repeat (6) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// Small, even, extreme and known values, with edge random words.
		foreach (known_primes[i]) queue_item(make_item(known_primes[i]));
		for (int c = 0; c < 10; c++) queue_item(make_item(64'(c)));
		queue_item(make_item(64'hFFFF_FFFF_FFFF_FFFF));
		queue_item(make_item(64'hFFFF_FFFF_FFFF_FFFE));
		queue_item(make_item(64'd561));
		queue_item(make_item(64'd3215031751));
		it = make_item(64'd18446744073709551557);
		it.rw = '{64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF};
		queue_item(it);
		it = make_item(64'd65537);
		it.rw = '{64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 64'hAAAA_AAAA_AAAA_AAAA,
			64'h5555_5555_5555_5555};
		queue_item(it);
		drain();

		// Pause until everything settles, then random phases with varied idling.
		hold_sender = 1;
		repeat (20) @(posedge clk);
		hold_sender = 0;
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = (ph == 1) ? 81 : (ph == 2) ? 21 : 0;
			for (int k = 0; k < 20; k++) begin
				int sel;
				sel = $urandom_range(9, 0);
				if (sel == 0) it = make_item({$urandom, $urandom});
				else if (sel == 1) it = make_item(known_primes[$urandom_range(5, 0)]);
				else if (sel == 2) it = make_item(rand_odd($urandom_range(12, 2)));
				else if (sel < 6) it = make_item(rand_odd($urandom_range(20, 8)));
				else it = make_item(rand_odd($urandom_range(64, 21)));
				queue_item(it);
			end
			drain();
		end

		$display("Checked %0d verdicts (%0d probably prime) over directed and random candidates.",
			verdicts_seen, primes_seen);
		if (errors == 0) $display("Simulation PASSED");
		else $display("Simulation FAILED");
		$finish;
	end

	initial begin
		#400ms;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

/* files.f */
sv/mrpt_pkg.sv
sv/mrpt_modunit.sv
sv/mrpt_seq.sv
sv/miller_rabin_prime_test_core.sv
bench/tb.sv
